[design/longest_edge_triangle_bisect_macros.svh]
// Assertion macros used by the checker file of the triangle bisection block.
`ifndef LONGEST_EDGE_TRIANGLE_BISECT_MACROS_SVH
`define LONGEST_EDGE_TRIANGLE_BISECT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define LETB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define LETB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`endif

[design/letb_pkg.sv]
// Types and constants of the longest-edge triangle bisection block.
`default_nettype none

package letb_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
	localparam int LEN_WIDTH   = 2 * COORD_WIDTH + 2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [COORD_WIDTH-1:0]        mag_t;
	typedef logic [SQ_WIDTH-1:0]           sq_t;
	typedef logic [LEN_WIDTH-1:0]          len_t;

	typedef coord_t [2:0] vec_t;
	typedef vec_t [2:0]   trio_t;

	typedef enum logic [1:0] {
		SIDE_0,
		SIDE_1,
		SIDE_2
	} side_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t az;
		coord_t bx;
		coord_t by;
		coord_t bz;
		coord_t cx;
		coord_t cy;
		coord_t cz;
	} shape_t;

	typedef struct packed {
		coord_t p0x;
		coord_t p0y;
		coord_t p0z;
		coord_t p1x;
		coord_t p1y;
		coord_t p1z;
		coord_t p2x;
		coord_t p2y;
		coord_t p2z;
		logic   last;
	} piece_t;

endpackage

`default_nettype wire

[design/longest_edge_triangle_bisect.sv]
// Top level of the longest-edge triangle bisection pipeline.
//
// The shape channel takes one triangle per item: three vertices, each with
// signed Q16.16 x, y and z coordinates. The piece channel returns two items
// for every triangle, the two halves made by splitting the longest edge at
// its midpoint, and the second of them carries last.
// Both channels use valid and stall; an item moves at a rising edge with
// valid high and stall low.
// The first half is presented after its triangle has passed through stages
// one to three into the output register, and the second half follows in the
// next cycle when the receiver does not stall. The output register sends both
// halves of a triangle in turn and takes no new one until the second goes.
// Three triangles can be in flight in the stages behind it.
// Stage one forms edge differences and midpoints, stage two squares the
// differences, stage three sums them into squared lengths, and the output
// register holds the chosen edge's two halves.
// A stall on the piece channel holds the output item and backs up the
// stages one by one until shape_stall rises; no item is lost or repeated.
// Reset clears all valid bits, so nothing is presented after reset.
`default_nettype none

module longest_edge_triangle_bisect (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            shape_valid,
	output logic                 shape_stall,
	input  wire letb_pkg::shape_t shape,
	output logic                 piece_valid,
	input  wire logic            piece_stall,
	output letb_pkg::piece_t     piece
);

	letb_pkg::trio_t vin;
	letb_pkg::mag_t  dabs [3][3];
	letb_pkg::trio_t mid;

	letb_pkg::trio_t v_s1, m_s1, v_s2, m_s2, v_s3, m_s3;
	letb_pkg::mag_t  d_s1 [3][3];
	letb_pkg::sq_t   sq_s2 [3][3];
	letb_pkg::len_t  len_s3 [3];
	logic            valid_s1, valid_s2, valid_s3;

	letb_pkg::vec_t  mid_q, ev_q, nv_q, op_q;
	logic            valid_q, phase_q;

	logic            adv1, adv2, adv3, out_rdy;
	logic            g10, g20, g21;
	letb_pkg::side_t side;
	letb_pkg::vec_t  mid_sel, ev_sel, nv_sel, op_sel;

	assign vin[0] = {shape.az, shape.ay, shape.ax};
	assign vin[1] = {shape.bz, shape.by, shape.bx};
	assign vin[2] = {shape.cz, shape.cy, shape.cx};

	for (genvar i = 0; i < 3; i++) begin : g_edge
		localparam int NXT = (i + 1) % 3;
		for (genvar k = 0; k < 3; k++) begin : g_axis
			logic [letb_pkg::COORD_WIDTH:0] diff, ndiff, msum;
			assign diff  = {vin[NXT][k][letb_pkg::COORD_WIDTH-1], vin[NXT][k]} -
				{vin[i][k][letb_pkg::COORD_WIDTH-1], vin[i][k]};
			assign ndiff = -diff;
			assign dabs[i][k] = diff[letb_pkg::COORD_WIDTH] ?
				ndiff[letb_pkg::COORD_WIDTH-1:0] : diff[letb_pkg::COORD_WIDTH-1:0];
			assign msum  = {vin[NXT][k][letb_pkg::COORD_WIDTH-1], vin[NXT][k]} +
				{vin[i][k][letb_pkg::COORD_WIDTH-1], vin[i][k]};
			assign mid[i][k] = msum[letb_pkg::COORD_WIDTH:1];
		end
	end

	assign out_rdy     = !valid_q || (phase_q && !piece_stall);
	assign adv3        = !valid_s3 || out_rdy;
	assign adv2        = !valid_s2 || adv3;
	assign adv1        = !valid_s1 || adv2;
	assign shape_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= shape_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (out_rdy) begin
				valid_q <= valid_s3;
				phase_q <= 1'b0;
			end else if (valid_q && !piece_stall) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && shape_valid) begin
			v_s1 <= vin;
			m_s1 <= mid;
			d_s1 <= dabs;
		end
		if (adv2 && valid_s1) begin
			v_s2 <= v_s1;
			m_s2 <= m_s1;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					sq_s2[i][k] <= d_s1[i][k] * d_s1[i][k];
				end
			end
		end
		if (adv3 && valid_s2) begin
			v_s3 <= v_s2;
			m_s3 <= m_s2;
			for (int i = 0; i < 3; i++) begin
				len_s3[i] <= letb_pkg::LEN_WIDTH'(sq_s2[i][0]) +
					letb_pkg::LEN_WIDTH'(sq_s2[i][1]) + letb_pkg::LEN_WIDTH'(sq_s2[i][2]);
			end
		end
		if (out_rdy && valid_s3) begin
			mid_q <= mid_sel;
			ev_q  <= ev_sel;
			nv_q  <= nv_sel;
			op_q  <= op_sel;
		end
	end

	assign g10 = len_s3[1] > len_s3[0];
	assign g20 = len_s3[2] > len_s3[0];
	assign g21 = len_s3[2] > len_s3[1];

	always_comb begin
		if (g10 ? g21 : g20) begin
			side = letb_pkg::SIDE_2;
		end else if (g10) begin
			side = letb_pkg::SIDE_1;
		end else begin
			side = letb_pkg::SIDE_0;
		end
	end

	always_comb begin
		unique case (side)
			letb_pkg::SIDE_1: begin
				mid_sel = m_s3[1];
				ev_sel  = v_s3[1];
				nv_sel  = v_s3[2];
				op_sel  = v_s3[0];
			end
			letb_pkg::SIDE_2: begin
				mid_sel = m_s3[2];
				ev_sel  = v_s3[2];
				nv_sel  = v_s3[0];
				op_sel  = v_s3[1];
			end
			default: begin
				mid_sel = m_s3[0];
				ev_sel  = v_s3[0];
				nv_sel  = v_s3[1];
				op_sel  = v_s3[2];
			end
		endcase
	end

	assign piece_valid = valid_q;
	assign piece.p0x   = mid_q[0];
	assign piece.p0y   = mid_q[1];
	assign piece.p0z   = mid_q[2];
	assign piece.p1x   = phase_q ? nv_q[0] : op_q[0];
	assign piece.p1y   = phase_q ? nv_q[1] : op_q[1];
	assign piece.p1z   = phase_q ? nv_q[2] : op_q[2];
	assign piece.p2x   = phase_q ? op_q[0] : ev_q[0];
	assign piece.p2y   = phase_q ? op_q[1] : ev_q[1];
	assign piece.p2z   = phase_q ? op_q[2] : ev_q[2];
	assign piece.last  = phase_q;

endmodule

`default_nettype wire

[design/letb_checker.sv]
// Port-level checker of the triangle bisection block and its bind.
`default_nettype none
`include "longest_edge_triangle_bisect_macros.svh"

module letb_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             piece_valid,
	input wire logic             piece_stall,
	input wire letb_pkg::piece_t piece
);

	`LETB_ASSERT_NEXT(a_piece_hold, piece_valid && piece_stall, piece_valid)
	`LETB_ASSERT_NEXT(a_piece_stable, piece_valid && piece_stall, $stable(piece))
	`LETB_ASSERT_NEXT(a_second_follows, piece_valid && !piece_stall && !piece.last,
		piece_valid && piece.last)
	`LETB_ASSERT_NEXT(a_first_after_last, piece_valid && !piece_stall && piece.last,
		!(piece_valid && piece.last))
	`LETB_ASSERT_NOW(a_same_midpoint,
		piece_valid && piece.last && $past(piece_valid && !piece_stall && !piece.last),
		piece.p0x == $past(piece.p0x) && piece.p0y == $past(piece.p0y) &&
		piece.p0z == $past(piece.p0z))

endmodule

bind longest_edge_triangle_bisect letb_checker u_letb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.piece_valid(piece_valid),
	.piece_stall(piece_stall),
	.piece(piece)
);

`default_nettype wire

[verif/longest_edge_triangle_bisect_tb.sv]
// Self-checking testbench for the longest-edge triangle bisection block.
`timescale 1ns / 100ps

module longest_edge_triangle_bisect_tb;
	import letb_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
	localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};

	class halves_ledger;
		piece_t halves_due[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int pending();
			return halves_due.size();
		endfunction

		task report(string what);
			if (mismatches < 40) begin
				$display("%0t: %s", $time, what);
			end
			mismatches++;
		endtask

		function void split_triangle(shape_t s);
			coord_t vtx[3][3];
			coord_t mid[3];
			len_t len[3];
			len_t best;
			mag_t mag;
			logic [COORD_WIDTH:0] diff;
			logic [COORD_WIDTH:0] sum;
			side_t longest;
			piece_t half;
			int i, j, k, e, n, o;

			vtx[0] = '{s.ax, s.ay, s.az};
			vtx[1] = '{s.bx, s.by, s.bz};
			vtx[2] = '{s.cx, s.cy, s.cz};

			for (i = 0; i < 3; i++) begin
				j = (i + 1) % 3;
				len[i] = '0;
				for (k = 0; k < 3; k++) begin
					diff = {vtx[j][k][COORD_WIDTH-1], vtx[j][k]}
						- {vtx[i][k][COORD_WIDTH-1], vtx[i][k]};
					mag = diff[COORD_WIDTH] ? ~diff[COORD_WIDTH-1:0] + 1'b1
						: diff[COORD_WIDTH-1:0];
					len[i] = len[i] + mag * mag;
				end
			end

			longest = SIDE_0;
			best = len[0];
			if (len[1] > best) begin
				longest = SIDE_1;
				best = len[1];
			end
			if (len[2] > best) begin
				longest = SIDE_2;
			end

			e = int'(longest);
			n = (e + 1) % 3;
			o = (e + 2) % 3;
			for (k = 0; k < 3; k++) begin
				sum = {vtx[e][k][COORD_WIDTH-1], vtx[e][k]}
					+ {vtx[n][k][COORD_WIDTH-1], vtx[n][k]};
				mid[k] = sum[COORD_WIDTH:1];
			end

			half.p0x = mid[0];
			half.p0y = mid[1];
			half.p0z = mid[2];
			half.p1x = vtx[o][0];
			half.p1y = vtx[o][1];
			half.p1z = vtx[o][2];
			half.p2x = vtx[e][0];
			half.p2y = vtx[e][1];
			half.p2z = vtx[e][2];
			half.last = 1'b0;
			halves_due = {halves_due, half};

			half.p1x = vtx[n][0];
			half.p1y = vtx[n][1];
			half.p1z = vtx[n][2];
			half.p2x = vtx[o][0];
			half.p2y = vtx[o][1];
			half.p2z = vtx[o][2];
			half.last = 1'b1;
			halves_due = {halves_due, half};
		endfunction

		task compare(string field, logic [COORD_WIDTH-1:0] got, logic [COORD_WIDTH-1:0] want);
			if (got !== want) begin
				report($sformatf("piece field %s is %h, expected %h", field, got, want));
			end
		endtask

		task check_piece(piece_t got);
			piece_t want;

			if (halves_due.size() == 0) begin
				report("piece item arrived with no triangle pending");
				return;
			end
			want = halves_due.pop_front();
			compare("p0x", got.p0x, want.p0x);
			compare("p0y", got.p0y, want.p0y);
			compare("p0z", got.p0z, want.p0z);
			compare("p1x", got.p1x, want.p1x);
			compare("p1y", got.p1y, want.p1y);
			compare("p1z", got.p1z, want.p1z);
			compare("p2x", got.p2x, want.p2x);
			compare("p2y", got.p2y, want.p2y);
			compare("p2z", got.p2z, want.p2z);
			compare("last", got.last, want.last);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic shape_valid;
	logic shape_stall;
	shape_t shape;
	logic piece_valid;
	logic piece_stall;
	piece_t piece;

	halves_ledger ledger;
	int pieces_taken = 0;
	int hold_req = 0;
	int idle_cycles = 0;
	bit send_quiet = 1'b0;
	bit recv_quiet = 1'b0;

	longest_edge_triangle_bisect u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.shape_valid(shape_valid),
		.shape_stall(shape_stall),
		.shape(shape),
		.piece_valid(piece_valid),
		.piece_stall(piece_stall),
		.piece(piece)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Drives one triangle and returns at the edge where it is taken.
	task automatic send_tri(input coord_t ax, input coord_t ay, input coord_t az,
			input coord_t bx, input coord_t by, input coord_t bz,
			input coord_t cx, input coord_t cy, input coord_t cz);
		shape_t s;
		int gap;

		s = '{ax, ay, az, bx, by, bz, cx, cy, cz};
		gap = send_quiet ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			shape_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		shape <= s;
		shape_valid <= 1'b1;
		do @(posedge clk); while (shape_stall);
		ledger.split_triangle(s);
	endtask

	function automatic coord_t pick_coord();
		coord_t v;

		case ($urandom_range(0, 9))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			3: return '1;
			4, 5: return coord_t'($urandom);
			6, 7: return coord_t'($urandom_range(0, 64)) - 32;
			default: begin
				v = $urandom >> $urandom_range(0, 31);
				return $urandom_range(0, 1) ? -v : v;
			end
		endcase
	endfunction

	task automatic send_random();
		coord_t p[3][3];
		coord_t x, y, z, t, w, base;
		int style, r, i, k;

		style = $urandom_range(0, 9);
		if (style < 3) begin
			for (i = 0; i < 3; i++) begin
				for (k = 0; k < 3; k++) begin
					p[i][k] = pick_coord();
				end
			end
		end else if (style < 6) begin
			// Swapping x and y keeps both vertices equally far from the third one.
			x = pick_coord();
			y = pick_coord();
			z = pick_coord();
			t = pick_coord();
			w = pick_coord();
			p[0] = '{x, y, z};
			p[1] = '{y, x, z};
			p[2] = '{t, t, w};
		end else if (style < 8) begin
			for (k = 0; k < 3; k++) begin
				base = $urandom;
				for (i = 0; i < 3; i++) begin
					p[i][k] = base + coord_t'($urandom_range(0, 8)) - 4;
				end
			end
		end else if (style == 8) begin
			for (k = 0; k < 3; k++) begin
				p[0][k] = pick_coord();
				p[2][k] = pick_coord();
			end
			p[1] = p[0];
		end else begin
			for (i = 0; i < 3; i++) begin
				for (k = 0; k < 3; k++) begin
					p[i][k] = $urandom;
				end
			end
		end

		r = $urandom_range(0, 2);
		send_tri(p[r][0], p[r][1], p[r][2],
			p[(r + 1) % 3][0], p[(r + 1) % 3][1], p[(r + 1) % 3][2],
			p[(r + 2) % 3][0], p[(r + 2) % 3][1], p[(r + 2) % 3][2]);
	endtask

	always @(posedge clk) begin
		if (arst_n && piece_valid && !piece_stall) begin
			ledger.check_piece(piece);
			pieces_taken++;
		end
	end

	// A new stall length is drawn after every piece item taken.
	initial begin
		int wait_left;
		int hold_left;
		int hold_seen;
		int seen;

		wait_left = 0;
		hold_left = 0;
		hold_seen = 0;
		seen = 0;
		piece_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_left = hold_req;
				hold_seen = hold_req;
			end
			if (pieces_taken != seen) begin
				seen = pieces_taken;
				wait_left = recv_quiet ? 0 : $urandom_range(0, 6);
			end
			if (hold_left > 0) begin
				piece_stall <= 1'b1;
				hold_left--;
			end else if (wait_left > 0) begin
				piece_stall <= 1'b1;
				wait_left--;
			end else begin
				piece_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((shape_valid && !shape_stall) || (piece_valid && !piece_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("longest_edge_triangle_bisect regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int n;

		arst_n = 1'b0;
		shape_valid = 1'b0;
		shape = '0;
		ledger = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_tri(1, 0, 0, 0, 1, 0, 0, 0, 1);
		send_tri(0, 0, 0, 10, 0, 0, 1, 1, 0);
		send_tri(0, 0, 0, 1, 0, 0, 0, 9, 0);
		send_tri(0, 0, 0, 4, 4, 0, 9, 0, 0);
		send_tri(-1, 0, 0, 0, 10, 0, 1, 0, 0);
		send_tri(-1, 0, 0, 1, 0, 0, 0, 10, 0);
		send_tri(0, 10, 0, -1, 0, 0, 1, 0, 0);
		send_tri(-3, -5, 7, 0, 0, 0, -1, -1, 1);
		send_tri(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0, 0, 0);
		send_tri(C_MAX, C_MIN, -1000, C_MAX, C_MIN, 1000, C_MAX, C_MIN, 0);
		send_tri(C_MIN, C_MAX, 0, C_MAX, C_MIN, -1, 1, -1, C_MIN);
		send_tri(0, 0, 0, 2, 2, 2, 5, 5, 5);
		send_tri(7, -7, 3, 7, -7, 3, 0, 0, 0);
		send_tri(5, 5, 5, -5, 1, 0, 5, 5, 5);
		send_tri(C_MIN, 0, 0, C_MAX, 0, 0, C_MAX, 0, 0);
		send_tri(0, C_MIN, 0, 0, 0, 0, 0, C_MAX, 0);
		send_tri(0, 0, C_MAX, 0, 0, C_MIN, -1, -1, -1);
		send_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1);
		send_tri(1, 3, 5, 2, 4, 6, 100, 101, -99);

		for (n = 0; n < 1750; n++) begin
			if (n % 150 == 0) begin
				send_quiet = ($urandom_range(0, 3) == 0);
				recv_quiet = ($urandom_range(0, 3) == 0);
			end
			if (n == 600) begin
				// The receiver backs off while triangles keep coming.
				hold_req = HOLD_CYCLES;
				send_quiet = 1'b1;
			end
			if (n == 1100) begin
				@(negedge clk);
				shape_valid <= 1'b0;
				while (ledger.pending() != 0) @(posedge clk);
			end
			send_random();
		end

		@(negedge clk);
		shape_valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (ledger.mismatches == 0) begin
			$display("longest_edge_triangle_bisect regression: pass");
		end else begin
			$display("longest_edge_triangle_bisect regression: fail");
		end
		$finish;
	end

endmodule

[longest_edge_triangle_bisect.f]
+incdir+design
design/letb_pkg.sv
design/longest_edge_triangle_bisect.sv
design/letb_checker.sv
verif/longest_edge_triangle_bisect_tb.sv
